@@ src/rtm_pkg.sv @@
// ----------------------------------------------------------------------------
// rtm_pkg
// shared types and constants of the interval map range table
// ----------------------------------------------------------------------------
package rtm_pkg;

	localparam int unsigned ENTRIES_DEF    = 64;
	localparam int unsigned KEY_BITS_DEF   = 32;
	localparam int unsigned VALUE_BITS_DEF = 8;

	typedef enum logic {
		OP_ASSIGN = 1'b0,
		OP_LOOKUP = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_PRE,
		S_INS_B,
		S_INS_E,
		S_POST,
		S_DONE
	} state_t;

endpackage

@@ src/rtm_mem.sv @@
// ----------------------------------------------------------------------------
// rtm_mem
// two-bank boundary memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rtm_mem #(
	parameter int unsigned ENTRIES = rtm_pkg::ENTRIES_DEF,
	parameter int unsigned DW      = rtm_pkg::KEY_BITS_DEF + rtm_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic                       wr_bank,
	input  logic [$clog2(ENTRIES)-1:0] wr_idx,
	input  logic [DW-1:0]              wr_data,
	input  logic                       rd_en,
	input  logic                       rd_bank,
	input  logic [$clog2(ENTRIES)-1:0] rd_idx,
	output logic [DW-1:0]              rd_data
);

	logic [DW-1:0] mem_q [2][ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_bank][wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_bank][rd_idx];
		end
	end

endmodule

@@ src/rtm_engine.sv @@
// ----------------------------------------------------------------------------
// rtm_engine
// scans the active bank, then, for a carried-out assign, rebuilds the table into the other bank
// ----------------------------------------------------------------------------
module rtm_engine #(
	parameter int unsigned ENTRIES    = rtm_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS   = rtm_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = rtm_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rtm_pkg::opcode_t                in_op,
	input  logic [KEY_BITS-1:0]             in_kb,
	input  logic [KEY_BITS-1:0]             in_ke,
	input  logic [VALUE_BITS-1:0]           in_val,
	input  logic [VALUE_BITS-1:0]           default_value,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [VALUE_BITS-1:0]           res_read_value,
	output rtm_pkg::status_t                res_status,
	output logic [$clog2(ENTRIES+1)-1:0]    res_count
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned DW = KEY_BITS + VALUE_BITS;

	rtm_pkg::state_t  state_q, state_d;
	rtm_pkg::opcode_t op_q;
	rtm_pkg::status_t stat_q, stat_d;
	logic [KEY_BITS-1:0]   kb_q, ke_q;
	logic [VALUE_BITS-1:0] v_q, left_q, right_q, look_q;
	logic [CW-1:0] i_q, j_q, p_q, m_q, used_q, lim;
	logic [CW:0]   n_q, n_d;
	logic          ins_b_q, ins_e_q, ins_b_d, ins_e_d;
	logic          pend_q, bank_q;

	logic          rd_en, wr_en;
	logic [DW-1:0] rd_data, wr_data;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic          copying;

	assign rd_key  = rd_data[DW-1:VALUE_BITS];
	assign rd_val  = rd_data[VALUE_BITS-1:0];
	assign copying = (state_q == rtm_pkg::S_PRE) || (state_q == rtm_pkg::S_POST);
	assign lim     = (state_q == rtm_pkg::S_PRE) ? p_q : used_q;

	always_comb begin
		rd_en = 1'b0;
		if (state_q == rtm_pkg::S_SCAN) begin
			rd_en = i_q < used_q;
		end else if (copying) begin
			rd_en = i_q < lim;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data;
		case (state_q)
			rtm_pkg::S_PRE, rtm_pkg::S_POST: wr_en = pend_q;
			rtm_pkg::S_INS_B: begin
				wr_en   = ins_b_q;
				wr_data = {kb_q, v_q};
			end
			rtm_pkg::S_INS_E: begin
				wr_en   = ins_e_q;
				wr_data = {ke_q, right_q};
			end
			default: wr_en = 1'b0;
		endcase
	end

	rtm_mem #(.ENTRIES(ENTRIES), .DW(DW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_bank (~bank_q),
		.wr_idx  (j_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_bank (bank_q),
		.rd_idx  (i_q[IW-1:0]),
		.rd_data (rd_data)
	);

	// table size after the assign and the decision on this item
	always_comb begin
		ins_b_d = left_q != v_q;
		ins_e_d = right_q != v_q;
		n_d = {1'b0, used_q} - {1'b0, m_q} + (CW+1)'(ins_b_d) + (CW+1)'(ins_e_d);
		if (op_q == rtm_pkg::OP_LOOKUP) begin
			stat_d = rtm_pkg::STAT_DONE;
		end else if (!(kb_q < ke_q)) begin
			stat_d = rtm_pkg::STAT_EMPTY;
		end else if (n_d > (CW+1)'(ENTRIES)) begin
			stat_d = rtm_pkg::STAT_FULL;
		end else begin
			stat_d = rtm_pkg::STAT_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			rtm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = rtm_pkg::S_SCAN;
			end
			rtm_pkg::S_SCAN: begin
				if (!rd_en && !pend_q) state_d = rtm_pkg::S_DECIDE;
			end
			rtm_pkg::S_DECIDE: begin
				if (op_q == rtm_pkg::OP_ASSIGN && kb_q < ke_q
						&& stat_d == rtm_pkg::STAT_DONE) begin
					state_d = rtm_pkg::S_PRE;
				end else begin
					state_d = rtm_pkg::S_DONE;
				end
			end
			rtm_pkg::S_PRE: begin
				if (!rd_en && !pend_q) state_d = rtm_pkg::S_INS_B;
			end
			rtm_pkg::S_INS_B: state_d = rtm_pkg::S_INS_E;
			rtm_pkg::S_INS_E: state_d = rtm_pkg::S_POST;
			rtm_pkg::S_POST: begin
				if (!rd_en && !pend_q) state_d = rtm_pkg::S_DONE;
			end
			rtm_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = rtm_pkg::S_IDLE;
			end
			default: state_d = rtm_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			bank_q <= 1'b0;
			used_q <= '0;
		end else begin
			pend_q <= rd_en;
			if (state_q == rtm_pkg::S_POST && !rd_en && !pend_q) begin
				bank_q <= ~bank_q;
				used_q <= n_q[CW-1:0];
			end
		end
	end

	// item payload and scan results
	always_ff @(posedge clk) begin
		if (rd_en) i_q <= i_q + 1'b1;
		if (wr_en) j_q <= j_q + 1'b1;
		case (state_q)
			rtm_pkg::S_IDLE: begin
				op_q    <= in_op;
				kb_q    <= in_kb;
				ke_q    <= in_ke;
				v_q     <= in_val;
				left_q  <= default_value;
				right_q <= default_value;
				look_q  <= default_value;
				i_q     <= '0;
				p_q     <= '0;
				m_q     <= '0;
			end
			rtm_pkg::S_SCAN: begin
				if (pend_q) begin
					if (rd_key < kb_q) begin
						p_q    <= p_q + 1'b1;
						left_q <= rd_val;
					end
					if (rd_key <= kb_q) look_q <= rd_val;
					if (rd_key >= kb_q && rd_key <= ke_q) m_q <= m_q + 1'b1;
					if (rd_key <= ke_q) right_q <= rd_val;
				end
			end
			rtm_pkg::S_DECIDE: begin
				i_q     <= '0;
				j_q     <= '0;
				ins_b_q <= ins_b_d;
				ins_e_q <= ins_e_d;
				n_q     <= n_d;
				stat_q  <= stat_d;
			end
			rtm_pkg::S_INS_E: i_q <= p_q + m_q;
			default: ;
		endcase
	end

	assign res_read_value = (op_q == rtm_pkg::OP_LOOKUP) ? look_q : '0;
	assign res_status     = stat_q;
	assign res_count      = used_q;

endmodule

@@ src/interval_map_range_table.sv @@
// ----------------------------------------------------------------------------
// interval_map_range_table
// sorted boundary table with range assign and point lookup
// ----------------------------------------------------------------------------
// flow: a lookup or an empty or refused assign scans the stored boundaries, decides,
// and m_tvalid rises from the output register; a carried-out assign first rebuilds
// the table: copy before, insert begin and end, copy after, then swap banks
// throughput: one transaction at a time, set by the single memory read port
// that streams the stored boundaries once for the scan and once for the copy
// reset: table empty, default_value 0, no result pending; memory needs no clear
module interval_map_range_table #(
	parameter int unsigned ENTRIES    = rtm_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS   = rtm_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = rtm_pkg::VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// config: default_value
	input  logic                  cfg_we,
	input  logic [VALUE_BITS-1:0] cfg_wdata,
	// input stream, tdata: key_begin, key_end, value (low bit first)
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((2*KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: opcode
	input  logic                  s_tuser,
	// output stream, tdata: read_value, boundaries_in_use (low bit first)
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((VALUE_BITS+$clog2(ENTRIES+1)+7)/8)*8-1:0] m_tdata,
	// tuser: status
	output logic [1:0]            m_tuser
);

	localparam int unsigned CW    = $clog2(ENTRIES + 1);
	localparam int unsigned OUT_W = ((VALUE_BITS + CW + 7) / 8) * 8;

	logic [VALUE_BITS-1:0] default_value_q;
	logic                  res_valid, res_ready;
	logic [VALUE_BITS-1:0] res_read_value;
	rtm_pkg::status_t      res_status;
	logic [CW-1:0]         res_count;
	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;
	logic [1:0]            m_tuser_q;

	// default value register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_value_q <= '0;
		end else if (cfg_we) begin
			default_value_q <= cfg_wdata;
		end
	end

	rtm_engine #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_op          (rtm_pkg::opcode_t'(s_tuser)),
		.in_kb          (s_tdata[KEY_BITS-1:0]),
		.in_ke          (s_tdata[2*KEY_BITS-1:KEY_BITS]),
		.in_val         (s_tdata[2*KEY_BITS+VALUE_BITS-1:2*KEY_BITS]),
		.default_value  (default_value_q),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_read_value (res_read_value),
		.res_status     (res_status),
		.res_count      (res_count)
	);

	// output register lets the engine take a new transaction while a result waits
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= OUT_W'({res_count, res_read_value});
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ src/rtm_checker.sv @@
// ----------------------------------------------------------------------------
// rtm_checker
// port-level checks of the interval map range table
// ----------------------------------------------------------------------------
module rtm_checker #(
	parameter int unsigned ENTRIES    = rtm_pkg::ENTRIES_DEF,
	parameter int unsigned VALUE_BITS = rtm_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((VALUE_BITS+$clog2(ENTRIES+1)+7)/8)*8-1:0] m_tdata,
	input logic [1:0] m_tuser
);

	localparam int unsigned CW = $clog2(ENTRIES + 1);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one transaction at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted while busy");

	// table never reports more boundaries than it holds
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[VALUE_BITS+CW-1:VALUE_BITS] <= CW'(ENTRIES))
		else $error("boundary count out of range");

	// status code is never the unused one
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= rtm_pkg::STAT_FULL)
		else $error("bad status code");

endmodule

bind interval_map_range_table rtm_checker #(
	.ENTRIES    (ENTRIES),
	.VALUE_BITS (VALUE_BITS)
) u_rtm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
